FILE: rtl/ptw_pkg.sv
// ptw_pkg: shared types and codes for the periodic timing wheel
// used by ptw_front, ptw_back and periodic_timing_wheel; no dependencies
package ptw_pkg;

    localparam int CMD_W       = 2;
    localparam int ID_W        = 4;
    localparam int PERIOD_IN_W = 16;
    localparam int KIND_W      = 2;

    // command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_REG    = 2'd0,
        OP_UNREG  = 2'd1,
        OP_TICK   = 2'd2,
        OP_REJECT = 2'd3
    } op_t;

    // result kind codes on the output channel
    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED  = 2'd0,
        KIND_REJECTED  = 2'd1,
        KIND_EXPIRED   = 2'd2,
        KIND_IDLE_TICK = 2'd3
    } kind_t;

    typedef struct packed {
        op_t             op;
        logic [ID_W-1:0] id;
    } ptw_cmd_t;

endpackage

FILE: rtl/ptw_ram.sv
// ptw_ram: generic single write port, single read port ram with registered read
// no dependencies
module ptw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ptw_front.sv
// ptw_front: accepts input words, classifies them and queues them for the back end
// depends on ptw_pkg
module ptw_front import ptw_pkg::*; #(
    parameter int TIMERS      = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_cmd,
    input  logic [ID_W-1:0]        s_timer_id,
    input  logic [PERIOD_IN_W-1:0] s_period,
    output logic                   q_valid,
    input  logic                   q_ready,
    output ptw_cmd_t               q_cmd,
    output logic [PERIOD_BITS-1:0] q_period
);

    ptw_cmd_t               cls_cmd;
    logic [PERIOD_BITS-1:0] cls_period;
    logic                   id_bad;

    ptw_cmd_t               slot_cmd_reg    [2];
    logic [PERIOD_BITS-1:0] slot_period_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             count_reg;
    logic                   push;
    logic                   pop;

    // period is taken in its low PERIOD_BITS bits
    assign cls_period = PERIOD_BITS'(s_period);
    assign id_bad     = (int'(s_timer_id) >= TIMERS);

    always_comb begin
        cls_cmd.id = s_timer_id;
        case (s_cmd)
            CMD_REGISTER: begin
                cls_cmd.op = (id_bad || (cls_period == '0)) ? OP_REJECT : OP_REG;
            end
            CMD_UNREGISTER: begin
                cls_cmd.op = id_bad ? OP_REJECT : OP_UNREG;
            end
            CMD_TICK: begin
                cls_cmd.op = OP_TICK;
            end
            default: begin
                cls_cmd.op = OP_REJECT;
            end
        endcase
    end

    // two-entry queue
    assign s_ready  = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign push     = s_valid && s_ready;
    assign pop      = q_valid && q_ready;
    assign q_cmd    = slot_cmd_reg[rd_ptr_reg];
    assign q_period = slot_period_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_cmd_reg[wr_ptr_reg]    <= cls_cmd;
            slot_period_reg[wr_ptr_reg] <= cls_period;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: rtl/ptw_back.sv
// ptw_back: executes queued operations against the timer table and drives results
// depends on ptw_pkg and ptw_ram
module ptw_back import ptw_pkg::*; #(
    parameter int TIMERS      = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  ptw_cmd_t               q_cmd,
    input  logic [PERIOD_BITS-1:0] q_period,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_result_kind,
    output logic [ID_W-1:0]        m_expired_id,
    output logic                   m_last
);

    localparam int IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int ENT_W = 2 * PERIOD_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMERS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [IDX_W-1:0]       eval_idx_reg;
    logic                   pend_valid_reg;
    logic [IDX_W-1:0]       pend_id_reg;
    logic [TIMERS-1:0]      active_reg;
    logic                   m_valid_reg;
    kind_t                  m_kind_reg;
    logic [ID_W-1:0]        m_id_reg;
    logic                   m_last_reg;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENT_W-1:0]       ram_wdata;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;

    logic [PERIOD_BITS-1:0] ent_period;
    logic [PERIOD_BITS-1:0] ent_remain;
    logic [IDX_W-1:0]       q_idx;
    logic                   out_free;
    logic                   eval_active;
    logic                   fire;
    logic                   scan_go;
    logic                   pop;
    logic                   out_load;

    // entry: period in the upper half, ticks left until expiry in the lower half
    ptw_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TIMERS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ent_period  = ram_rdata[ENT_W-1:PERIOD_BITS];
    assign ent_remain  = ram_rdata[PERIOD_BITS-1:0];
    assign q_idx       = IDX_W'(q_cmd.id);
    assign out_free    = !m_valid_reg || m_ready;
    assign eval_active = active_reg[eval_idx_reg];
    assign fire        = eval_active && (ent_remain == PERIOD_BITS'(1));
    // a second expiry needs the output register to pass on the pending one
    assign scan_go     = !(fire && pend_valid_reg && !out_free);
    assign q_ready     = (state_reg == ST_IDLE) && out_free;
    assign pop         = q_valid && q_ready;
    // a new result word goes into the output register this cycle
    assign out_load    = ((state_reg == ST_IDLE) && pop && (q_cmd.op != OP_TICK))
                      || ((state_reg == ST_SCAN) && scan_go && fire && pend_valid_reg)
                      || ((state_reg == ST_DONE) && out_free);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            ST_IDLE: begin
                if (pop && (q_cmd.op == OP_REG)) begin
                    ram_we    = 1'b1;
                    ram_waddr = q_idx;
                    ram_wdata = {q_period, q_period};
                end
                if (pop && (q_cmd.op == OP_TICK)) begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end
            end
            ST_SCAN: begin
                if (scan_go) begin
                    ram_we    = eval_active;
                    ram_waddr = eval_idx_reg;
                    ram_wdata = fire ? {ent_period, ent_period}
                                     : {ent_period, ent_remain - PERIOD_BITS'(1)};
                    if (eval_idx_reg != LAST_IDX) begin
                        ram_re    = 1'b1;
                        ram_raddr = eval_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            eval_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            active_reg     <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        case (q_cmd.op)
                            OP_REG, OP_UNREG: begin
                                active_reg[q_idx] <= (q_cmd.op == OP_REG);
                                m_valid_reg       <= 1'b1;
                                m_kind_reg        <= KIND_ACCEPTED;
                                m_id_reg          <= q_cmd.id;
                                m_last_reg        <= 1'b1;
                            end
                            OP_TICK: begin
                                eval_idx_reg <= '0;
                                state_reg    <= ST_SCAN;
                            end
                            default: begin
                                m_valid_reg <= 1'b1;
                                m_kind_reg  <= KIND_REJECTED;
                                m_id_reg    <= q_cmd.id;
                                m_last_reg  <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (scan_go) begin
                        if (fire) begin
                            if (pend_valid_reg) begin
                                m_valid_reg <= 1'b1;
                                m_kind_reg  <= KIND_EXPIRED;
                                m_id_reg    <= ID_W'(pend_id_reg);
                                m_last_reg  <= 1'b0;
                            end
                            pend_id_reg    <= eval_idx_reg;
                            pend_valid_reg <= 1'b1;
                        end
                        if (eval_idx_reg == LAST_IDX) begin
                            state_reg <= ST_DONE;
                        end else begin
                            eval_idx_reg <= eval_idx_reg + IDX_W'(1);
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        m_kind_reg     <= pend_valid_reg ? KIND_EXPIRED : KIND_IDLE_TICK;
                        m_id_reg       <= pend_valid_reg ? ID_W'(pend_id_reg) : '0;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_expired_id  = m_id_reg;
    assign m_last        = m_last_reg;

endmodule

FILE: rtl/periodic_timing_wheel.sv
// periodic_timing_wheel: top level of the periodic timer block
// depends on ptw_pkg, ptw_front, ptw_back (and ptw_ram through ptw_back)

// Periodic timer block for up to TIMERS timers. A register word (cmd 0) arms
// timer timer_id with a period of p ticks (low PERIOD_BITS bits of period) so
// that it expires every p ticks from then on; re-arming an active id replaces
// it. An unregister word (cmd 1) disarms the timer. A tick word (cmd 2) moves
// time on by one and returns one result word per expiring timer, in
// ascending id order, with last on the final one, or a single "tick with no
// expiry" word. A zero period, an id of TIMERS or above, or cmd 3 gives one
// rejected word. Each table entry keeps its period and the ticks left until
// expiry, which gives the same expiry times as a wheel slot and round count
// with no division. A register, unregister or rejected word goes from the
// queue straight into the result register; a tick walks the whole timer
// table through its ram (one write port, one read port), one entry per
// cycle while the result side does not stall. A two-word queue sits
// between the input classifier and the executing back end and keeps taking
// words while a result waits in the result register; the back end takes no
// new word until that result has gone.
module periodic_timing_wheel import ptw_pkg::*; #(
    parameter int TIMERS      = 16,
    parameter int PERIOD_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input words
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_W-1:0]       s_cmd,
    input  logic [ID_W-1:0]        s_timer_id,
    input  logic [PERIOD_IN_W-1:0] s_period,
    // result words
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [KIND_W-1:0]      m_result_kind,
    output logic [ID_W-1:0]        m_expired_id,
    output logic                   m_last
);

    // classified words between front and back
    logic                   q_valid;
    logic                   q_ready;
    ptw_cmd_t               q_cmd;
    logic [PERIOD_BITS-1:0] q_period;

    // front: decode, range checks and the two-word queue
    ptw_front #(
        .TIMERS      (TIMERS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_timer_id (s_timer_id),
        .s_period   (s_period),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_cmd      (q_cmd),
        .q_period   (q_period)
    );

    // back: timer table, tick scan and result register
    ptw_back #(
        .TIMERS      (TIMERS),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .q_period      (q_period),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_expired_id  (m_expired_id),
        .m_last        (m_last)
    );

endmodule
